[sv/tgard_pkg.sv]
// Shared types, register indexes and constants of the run-length pixel decoder.
package tgard_pkg;

    localparam int COUNT_BITS = 32;

    // configuration register indexes
    localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [1:0] CFG_ALPHA_ENABLE    = 2'd1;
    localparam logic [1:0] CFG_RLE_ENABLE      = 2'd2;
    localparam logic [1:0] CFG_PIXEL_COUNT     = 2'd3;

    // pixel sizes in the stream
    localparam logic [2:0] BPP_GREY   = 3'd1;
    localparam logic [2:0] BPP_RGB555 = 3'd2;
    localparam logic [2:0] BPP_BGR    = 3'd3;
    localparam logic [2:0] BPP_BGRA   = 3'd4;

    localparam logic [7:0] HDR_RUN_BIT = 8'h80;
    localparam logic [7:0] HDR_COUNT   = 8'h7F;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    // 5-bit channel scaled by 255/31, truncated
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [7:0] r;
        unique case (v)
            5'd0:  r = 8'd0;
            5'd1:  r = 8'd8;
            5'd2:  r = 8'd16;
            5'd3:  r = 8'd24;
            5'd4:  r = 8'd32;
            5'd5:  r = 8'd41;
            5'd6:  r = 8'd49;
            5'd7:  r = 8'd57;
            5'd8:  r = 8'd65;
            5'd9:  r = 8'd74;
            5'd10: r = 8'd82;
            5'd11: r = 8'd90;
            5'd12: r = 8'd98;
            5'd13: r = 8'd106;
            5'd14: r = 8'd115;
            5'd15: r = 8'd123;
            5'd16: r = 8'd131;
            5'd17: r = 8'd139;
            5'd18: r = 8'd148;
            5'd19: r = 8'd156;
            5'd20: r = 8'd164;
            5'd21: r = 8'd172;
            5'd22: r = 8'd180;
            5'd23: r = 8'd189;
            5'd24: r = 8'd197;
            5'd25: r = 8'd205;
            5'd26: r = 8'd213;
            5'd27: r = 8'd222;
            5'd28: r = 8'd230;
            5'd29: r = 8'd238;
            5'd30: r = 8'd246;
            default: r = 8'd255;
        endcase
        return r;
    endfunction

endpackage

[sv/tgard_if.sv]
// Stream channels of the decoder: data bytes in, decoded pixels out.
interface tgard_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface tgard_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_res;
    logic       last;
    logic       overrun;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output repeat_res, output last, output overrun, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input repeat_res, input last, input overrun, output ready);
endinterface

[sv/tgard_pixel_conv.sv]
// Converts an assembled little-endian pixel of 1 to 4 bytes to 8-bit RGBA.
module tgard_pixel_conv (
    input  logic [31:0]          full,
    input  logic [2:0]           bpp,
    input  logic                 alpha_enable,
    output tgard_pkg::rgba_t     pixel
);
    import tgard_pkg::*;

    always_comb
    begin
        pixel.alpha = 8'd0;
        unique case (bpp)
            BPP_GREY:
            begin
                pixel.red   = full[7:0];
                pixel.green = full[7:0];
                pixel.blue  = full[7:0];
            end
            BPP_RGB555:
            begin
                pixel.red   = expand5(full[14:10]);
                pixel.green = expand5(full[9:5]);
                pixel.blue  = expand5(full[4:0]);
                if (alpha_enable && full[15])
                begin
                    pixel.alpha = 8'hFF;
                end
            end
            default:
            begin
                // BGR byte order in the stream
                pixel.red   = full[23:16];
                pixel.green = full[15:8];
                pixel.blue  = full[7:0];
                if (bpp == BPP_BGRA && alpha_enable)
                begin
                    pixel.alpha = full[31:24];
                end
            end
        endcase
    end

endmodule

[sv/tga_rle_pixel_decoder.sv]
// Run-length image pixel decoder: takes one data byte per clock and gives one
// RGBA pixel with a repeat count per completed pixel. A byte is accepted in every
// cycle, back to back, as long as the pixel output is not held; its result, if any,
// passes through the input register, then the result register. A result held by the
// sink stalls the byte behind it in the input register, and the input takes a new
// byte in the cycle that register moves on. The packet and pixel counters are
// updated once per byte, which allows one byte per clock. first_byte starts a new
// image and loads pixel_count; the result that finishes the image has last set, a
// run longer than the pixels left is clipped, and overrun marks a packet longer than
// the pixels left. Bytes after the image ends are dropped until the next
// first_byte. Write configuration only while no byte or pixel is in flight.
module tga_rle_pixel_decoder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    tgard_in_if.sink      byte_ch,
    tgard_out_if.source   pixel_ch
);
    import tgard_pkg::*;

    // configuration
    logic [2:0]   bpp_cfg_reg;
    logic         alpha_en_reg;
    logic         rle_en_reg;
    logic [31:0]  pixel_count_reg;

    // input register
    logic         s1_valid_reg, s1_valid_next;
    logic [7:0]   s1_byte_reg;
    logic         s1_first_reg;

    // decoder state
    logic         expect_header_reg, expect_header_next;
    logic         packet_is_run_reg, packet_is_run_next;
    logic [7:0]   packet_left_reg, packet_left_next;
    logic [1:0]   byte_slot_reg, byte_slot_next;
    logic [23:0]  pixel_bytes_reg, pixel_bytes_next;
    count_t       pixels_left_reg, pixels_left_next;
    logic         image_done_reg, image_done_next;

    // result register
    logic         out_valid_reg, out_valid_next;
    rgba_t        out_pixel_reg;
    logic [7:0]   out_repeat_reg;
    logic         out_last_reg;
    logic         out_overrun_reg;

    logic         advance;
    logic         emit;
    logic         byte_accept;
    logic [2:0]   bpp;
    logic [31:0]  full;
    logic [7:0]   pl;
    logic [7:0]   rep;
    logic         ovr;
    rgba_t        conv_pixel;

    assign advance     = s1_valid_reg && (!out_valid_reg || pixel_ch.ready);
    assign byte_ch.ready = !s1_valid_reg || advance;
    assign byte_accept = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        if (bpp_cfg_reg == 3'd0)
        begin
            bpp = BPP_GREY;
        end
        else if (bpp_cfg_reg > BPP_BGRA)
        begin
            bpp = BPP_BGRA;
        end
        else
        begin
            bpp = bpp_cfg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_cfg_reg     <= BPP_BGR;
            alpha_en_reg    <= 1'b0;
            rle_en_reg      <= 1'b1;
            pixel_count_reg <= 32'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BYTES_PER_PIXEL: bpp_cfg_reg     <= cfg_data[2:0];
                CFG_ALPHA_ENABLE:    alpha_en_reg    <= cfg_data[0];
                CFG_RLE_ENABLE:      rle_en_reg      <= cfg_data[0];
                default:             pixel_count_reg <= cfg_data;
            endcase
        end
    end

    // next state of the decoder for the byte in the input register
    always_comb
    begin
        expect_header_next = expect_header_reg;
        packet_is_run_next = packet_is_run_reg;
        packet_left_next   = packet_left_reg;
        byte_slot_next     = byte_slot_reg;
        pixel_bytes_next   = pixel_bytes_reg;
        pixels_left_next   = pixels_left_reg;
        image_done_next    = image_done_reg;
        emit               = 1'b0;
        full               = 32'd0;
        pl                 = 8'd1;
        rep                = 8'd1;
        ovr                = 1'b0;

        if (s1_first_reg)
        begin
            expect_header_next = 1'b1;
            packet_is_run_next = 1'b0;
            packet_left_next   = 8'd0;
            byte_slot_next     = 2'd0;
            pixel_bytes_next   = 24'd0;
            pixels_left_next   = pixel_count_reg[COUNT_BITS-1:0];
            image_done_next    = (pixel_count_reg[COUNT_BITS-1:0] == '0);
        end

        if (!image_done_next)
        begin
            if (rle_en_reg && expect_header_next)
            begin
                packet_is_run_next = (s1_byte_reg & HDR_RUN_BIT) != 8'd0;
                packet_left_next   = (s1_byte_reg & HDR_COUNT) + 8'd1;
                expect_header_next = 1'b0;
                byte_slot_next     = 2'd0;
                pixel_bytes_next   = 24'd0;
            end
            else
            begin
                full = {8'd0, pixel_bytes_next}
                     | ({24'd0, s1_byte_reg} << {byte_slot_next, 3'b000});
                if (({1'b0, byte_slot_next} + 3'd1) < bpp)
                begin
                    pixel_bytes_next = full[23:0];
                    byte_slot_next   = byte_slot_next + 2'd1;
                end
                else
                begin
                    emit             = 1'b1;
                    byte_slot_next   = 2'd0;
                    pixel_bytes_next = 24'd0;
                    if (rle_en_reg)
                    begin
                        pl  = (packet_left_next == 8'd0) ? 8'd1 : packet_left_next;
                        ovr = COUNT_BITS'(pl) > pixels_left_next;
                        rep = packet_is_run_next ? pl : 8'd1;
                        if (COUNT_BITS'(rep) > pixels_left_next)
                        begin
                            rep = pixels_left_next[7:0];
                        end
                        packet_left_next = packet_is_run_next ? 8'd0 : pl - 8'd1;
                        if (packet_left_next == 8'd0)
                        begin
                            expect_header_next = 1'b1;
                        end
                    end
                    pixels_left_next = pixels_left_next - COUNT_BITS'(rep);
                    if (pixels_left_next == '0)
                    begin
                        image_done_next    = 1'b1;
                        expect_header_next = 1'b1;
                        packet_is_run_next = 1'b0;
                        packet_left_next   = 8'd0;
                        byte_slot_next     = 2'd0;
                        pixel_bytes_next   = 24'd0;
                    end
                end
            end
        end
    end

    tgard_pixel_conv u_conv (
        .full         (full),
        .bpp          (bpp),
        .alpha_enable (alpha_en_reg),
        .pixel        (conv_pixel)
    );

    always_comb
    begin
        if (byte_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = emit;
        end
        else if (pixel_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            packet_left_reg   <= 8'd0;
            byte_slot_reg     <= 2'd0;
            pixel_bytes_reg   <= 24'd0;
            pixels_left_reg   <= '0;
            image_done_reg    <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                expect_header_reg <= expect_header_next;
                packet_is_run_reg <= packet_is_run_next;
                packet_left_reg   <= packet_left_next;
                byte_slot_reg     <= byte_slot_next;
                pixel_bytes_reg   <= pixel_bytes_next;
                pixels_left_reg   <= pixels_left_next;
                image_done_reg    <= image_done_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            s1_byte_reg  <= byte_ch.data_byte;
            s1_first_reg <= byte_ch.first_byte;
        end
        if (advance && emit)
        begin
            out_pixel_reg   <= conv_pixel;
            out_repeat_reg  <= rep;
            out_last_reg    <= image_done_next;
            out_overrun_reg <= ovr;
        end
    end

    assign pixel_ch.valid      = out_valid_reg;
    assign pixel_ch.red        = out_pixel_reg.red;
    assign pixel_ch.green      = out_pixel_reg.green;
    assign pixel_ch.blue       = out_pixel_reg.blue;
    assign pixel_ch.alpha      = out_pixel_reg.alpha;
    assign pixel_ch.repeat_res = out_repeat_reg;
    assign pixel_ch.last       = out_last_reg;
    assign pixel_ch.overrun    = out_overrun_reg;

endmodule
